// ===== hw/rtl/lzwdd_pkg.sv =====
// ----------------------------------------------------------------------------
// LZW delta byte decoder package
// Shared constants, the dictionary entry type and the sequencer states.
// ----------------------------------------------------------------------------
package lzwdd_pkg;

    localparam int DICT_CODES_DEF = 16384;
    localparam int ROOT_BITS      = 8;
    localparam int CODE_W         = 14;
    localparam int WIDTH_W        = 4;
    localparam int CMP_W          = 17;

    localparam logic [CODE_W-1:0]  CTRL_CLEAR = CODE_W'(256);
    localparam logic [CODE_W-1:0]  CTRL_END   = CODE_W'(257);
    localparam logic [CMP_W-1:0]   FIRST_FREE = CMP_W'(258);
    localparam logic [WIDTH_W-1:0] MIN_WIDTH  = WIDTH_W'(9);
    localparam logic [WIDTH_W-1:0] MAX_WIDTH  = WIDTH_W'(14);

    localparam logic CMD_CODE  = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    typedef struct packed {
        logic [CODE_W-1:0]    prefix;
        logic [ROOT_BITS-1:0] ch;
    } dict_entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP,
        S_ISSUE,
        S_WALK,
        S_ROOT
    } state_t;

endpackage

// ===== hw/rtl/lzw_delta_byte_decoder_core.sv =====
// ----------------------------------------------------------------------------
// LZW delta byte decoder core
// Expands LZW codes onto a reversal stack and emits running-sum bytes.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid/in_ready) carries items with cmd and
// code. A code item (cmd 0) is decoded and its string is pushed onto the
// reversal stack; a drain item (cmd 1) pops one byte if the stack holds one,
// adds it to the running sum and returns that sum. Every input item yields
// exactly one result item on the output channel (out_valid/out_ready).
// code_width tells upstream how many bits to unpack for the next code and
// stream_end is sticky after the end code.
// Sequence: a drain item reads the stack and forms its result in S_POP; a
// literal, control or rejected code completes in S_IDLE, and any other code
// walks its string in S_WALK and ends in S_ROOT (through S_ISSUE first when
// the code is the one about to be added). The dictionary walk reads one
// entry per cycle from the dictionary memory, so that chain sets the time.
// The block works on one item at a time; a new item is taken the cycle after
// the previous result has left the output register.
// Reset clears all control state; the dictionary and stack memories are not
// cleared and are only read where written. When the receiver stalls, the
// result holds in the output register and in_ready stays low.
// ----------------------------------------------------------------------------
module lzw_delta_byte_decoder_core #(
    parameter int DICT_CODES = lzwdd_pkg::DICT_CODES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             cmd,
    input  logic [lzwdd_pkg::CODE_W-1:0]     code,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             byte_valid,
    output logic [lzwdd_pkg::ROOT_BITS-1:0]  data_byte,
    output logic                             string_last,
    output logic                             stream_end,
    output logic [lzwdd_pkg::WIDTH_W-1:0]    code_width,
    output logic                             code_error
);

    localparam int AW  = $clog2(DICT_CODES);
    localparam int NFW = AW + 1;
    localparam int CW  = lzwdd_pkg::CODE_W;
    localparam int RB  = lzwdd_pkg::ROOT_BITS;
    localparam int XW  = lzwdd_pkg::CMP_W;
    localparam logic [XW-1:0] DICT_LIMIT = XW'(DICT_CODES);

    lzwdd_pkg::state_t state_reg, state_next;

    logic [NFW-1:0] nf_reg, nf_next;
    logic [lzwdd_pkg::WIDTH_W-1:0] width_reg, width_next;
    logic [CW-1:0]  prev_reg, prev_next;
    logic [RB-1:0]  first_reg, first_next;
    logic [RB-1:0]  sum_reg, sum_next;
    logic           aclr_reg, aclr_next;
    logic [NFW-1:0] cnt_reg, cnt_next;
    logic           ended_reg, ended_next;
    logic [CW-1:0]  cur_reg, cur_next;
    logic           kw_reg, kw_next;
    logic [RB-1:0]  root_reg, root_next;

    logic           ov_reg, ov_next;
    logic           bv_reg, bv_next;
    logic [RB-1:0]  db_reg, db_next;
    logic           sl_reg, sl_next;
    logic           er_reg, er_next;

    // Dictionary port signals.
    logic                   d_we;
    logic [AW-1:0]          d_waddr;
    lzwdd_pkg::dict_entry_t d_wdata;
    logic [AW-1:0]          d_raddr;
    lzwdd_pkg::dict_entry_t d_rdata;

    // Reversal stack memory.
    logic [RB-1:0] stack_mem [DICT_CODES];
    logic          s_we;
    logic [AW-1:0] s_waddr;
    logic [RB-1:0] s_wdata;
    logic [AW-1:0] s_raddr;
    logic [RB-1:0] s_rdata;

    logic          in_acc;
    logic [XW-1:0] code_x;
    logic [XW-1:0] nf_x;
    logic          add_req;
    logic [CW-1:0] add_prefix;
    logic [RB-1:0] add_char;
    logic [XW-1:0] nf_inc;
    logic [XW-1:0] grow_lim;

    lzwdd_dict #(
        .DICT_CODES(DICT_CODES)
    ) u_dict (
        .clk  (clk),
        .we   (d_we),
        .waddr(d_waddr),
        .wdata(d_wdata),
        .raddr(d_raddr),
        .rdata(d_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (s_we)
        begin
            stack_mem[s_waddr] <= s_wdata;
        end
        s_rdata <= stack_mem[s_raddr];
    end

    assign in_ready  = (state_reg == lzwdd_pkg::S_IDLE) && !ov_reg;
    assign in_acc    = in_valid && in_ready;
    assign code_x    = XW'(code);
    assign nf_x      = XW'(nf_reg);
    assign nf_inc    = nf_x + XW'(1);
    assign grow_lim  = (XW'(1) << width_reg) - XW'(1);

    assign out_valid   = ov_reg;
    assign byte_valid  = bv_reg;
    assign data_byte   = db_reg;
    assign string_last = sl_reg;
    assign code_error  = er_reg;
    assign stream_end  = ended_reg;
    assign code_width  = width_reg;

    always_comb
    begin
        state_next = state_reg;
        nf_next    = nf_reg;
        width_next = width_reg;
        prev_next  = prev_reg;
        first_next = first_reg;
        sum_next   = sum_reg;
        aclr_next  = aclr_reg;
        cnt_next   = cnt_reg;
        ended_next = ended_reg;
        cur_next   = cur_reg;
        kw_next    = kw_reg;
        root_next  = root_reg;
        ov_next    = ov_reg && !out_ready;
        bv_next    = bv_reg;
        db_next    = db_reg;
        sl_next    = sl_reg;
        er_next    = er_reg;
        add_req    = 1'b0;
        add_prefix = prev_reg;
        add_char   = first_reg;
        d_raddr    = AW'(cur_reg);
        s_we       = 1'b0;
        s_waddr    = AW'(cnt_reg);
        s_wdata    = root_reg;
        s_raddr    = AW'(cnt_reg - NFW'(1));

        unique case (state_reg)
            lzwdd_pkg::S_IDLE:
            begin
                if (in_acc)
                begin
                    // Result defaults for an item that completes at once.
                    bv_next = 1'b0;
                    db_next = '0;
                    sl_next = 1'b0;
                    er_next = 1'b0;
                    if (cmd == lzwdd_pkg::CMD_DRAIN)
                    begin
                        if (cnt_reg != '0)
                        begin
                            cnt_next   = cnt_reg - NFW'(1);
                            state_next = lzwdd_pkg::S_POP;
                        end
                        else
                        begin
                            ov_next = 1'b1;
                        end
                    end
                    else if (cnt_reg != '0 || ended_reg)
                    begin
                        er_next = 1'b1;
                        ov_next = 1'b1;
                    end
                    else if (code == lzwdd_pkg::CTRL_CLEAR)
                    begin
                        sum_next   = '0;
                        nf_next    = NFW'(lzwdd_pkg::FIRST_FREE);
                        width_next = lzwdd_pkg::MIN_WIDTH;
                        aclr_next  = 1'b1;
                        ov_next    = 1'b1;
                    end
                    else if (code == lzwdd_pkg::CTRL_END)
                    begin
                        ended_next = 1'b1;
                        ov_next    = 1'b1;
                    end
                    else if (aclr_reg)
                    begin
                        if (code >= lzwdd_pkg::CTRL_CLEAR)
                        begin
                            er_next = 1'b1;
                        end
                        else
                        begin
                            s_we       = 1'b1;
                            s_wdata    = code[RB-1:0];
                            cnt_next   = NFW'(1);
                            prev_next  = code;
                            first_next = code[RB-1:0];
                            aclr_next  = 1'b0;
                        end
                        ov_next = 1'b1;
                    end
                    else if (code_x < nf_x)
                    begin
                        cur_next = code;
                        kw_next  = 1'b0;
                        if (code < lzwdd_pkg::CTRL_CLEAR)
                        begin
                            // A literal is its own one-byte string.
                            s_we       = 1'b1;
                            s_wdata    = code[RB-1:0];
                            cnt_next   = NFW'(1);
                            add_req    = 1'b1;
                            add_char   = code[RB-1:0];
                            prev_next  = code;
                            first_next = code[RB-1:0];
                            ov_next    = 1'b1;
                        end
                        else
                        begin
                            d_raddr    = AW'(code);
                            state_next = lzwdd_pkg::S_WALK;
                        end
                    end
                    else if (code_x == nf_x && nf_x < DICT_LIMIT)
                    begin
                        // The code names the entry being defined right now.
                        add_req    = 1'b1;
                        cur_next   = code;
                        kw_next    = 1'b1;
                        state_next = lzwdd_pkg::S_ISSUE;
                    end
                    else
                    begin
                        er_next = 1'b1;
                        ov_next = 1'b1;
                    end
                end
            end

            lzwdd_pkg::S_POP:
            begin
                sum_next   = sum_reg + s_rdata;
                bv_next    = 1'b1;
                db_next    = sum_reg + s_rdata;
                sl_next    = (cnt_reg == '0);
                ov_next    = 1'b1;
                state_next = lzwdd_pkg::S_IDLE;
            end

            lzwdd_pkg::S_ISSUE:
            begin
                d_raddr    = AW'(cur_reg);
                state_next = lzwdd_pkg::S_WALK;
            end

            lzwdd_pkg::S_WALK:
            begin
                s_we     = 1'b1;
                s_wdata  = d_rdata.ch;
                cnt_next = cnt_reg + NFW'(1);
                d_raddr  = AW'(d_rdata.prefix);
                if (d_rdata.prefix < lzwdd_pkg::CTRL_CLEAR)
                begin
                    root_next  = d_rdata.prefix[RB-1:0];
                    state_next = lzwdd_pkg::S_ROOT;
                end
            end

            lzwdd_pkg::S_ROOT:
            begin
                s_we      = 1'b1;
                s_wdata   = root_reg;
                cnt_next  = cnt_reg + NFW'(1);
                prev_next = cur_reg;
                if (!kw_reg)
                begin
                    add_req    = 1'b1;
                    add_char   = root_reg;
                    first_next = root_reg;
                end
                ov_next    = 1'b1;
                state_next = lzwdd_pkg::S_IDLE;
            end

            default:
            begin
                state_next = lzwdd_pkg::S_IDLE;
            end
        endcase

        // New dictionary entry with early width growth, saturating.
        d_we           = 1'b0;
        d_waddr        = AW'(nf_reg);
        d_wdata.prefix = add_prefix;
        d_wdata.ch     = add_char;
        if (add_req && nf_x < DICT_LIMIT)
        begin
            d_we    = 1'b1;
            nf_next = NFW'(nf_inc);
            if (width_reg < lzwdd_pkg::MAX_WIDTH && nf_inc >= grow_lim)
            begin
                width_next = width_reg + lzwdd_pkg::WIDTH_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lzwdd_pkg::S_IDLE;
            nf_reg    <= NFW'(lzwdd_pkg::FIRST_FREE);
            width_reg <= lzwdd_pkg::MIN_WIDTH;
            prev_reg  <= '0;
            first_reg <= '0;
            sum_reg   <= '0;
            aclr_reg  <= 1'b1;
            cnt_reg   <= '0;
            ended_reg <= 1'b0;
            kw_reg    <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            nf_reg    <= nf_next;
            width_reg <= width_next;
            prev_reg  <= prev_next;
            first_reg <= first_next;
            sum_reg   <= sum_next;
            aclr_reg  <= aclr_next;
            cnt_reg   <= cnt_next;
            ended_reg <= ended_next;
            kw_reg    <= kw_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        root_reg <= root_next;
        bv_reg   <= bv_next;
        db_reg   <= db_next;
        sl_reg   <= sl_next;
        er_reg   <= er_next;
    end

endmodule

// ===== hw/rtl/lzwdd_dict.sv =====
// ----------------------------------------------------------------------------
// LZW dictionary memory
// One write port and one registered read port holding prefix and character.
// ----------------------------------------------------------------------------
module lzwdd_dict #(
    parameter int DICT_CODES = lzwdd_pkg::DICT_CODES_DEF,
    localparam int AW = $clog2(DICT_CODES)
) (
    input  logic                    clk,
    input  logic                    we,
    input  logic [AW-1:0]           waddr,
    input  lzwdd_pkg::dict_entry_t  wdata,
    input  logic [AW-1:0]           raddr,
    output lzwdd_pkg::dict_entry_t  rdata
);

    lzwdd_pkg::dict_entry_t mem [DICT_CODES];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/lzwdd_checker.sv =====
// ----------------------------------------------------------------------------
// LZW delta byte decoder port checker
// Watches the top-level ports over time and is bound to the core.
// ----------------------------------------------------------------------------
module lzwdd_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic                             byte_valid,
    input logic                             string_last,
    input logic                             stream_end,
    input logic [lzwdd_pkg::WIDTH_W-1:0]    code_width,
    input logic                             code_error
);

    // A held result does not drop before it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // A byte result is never flagged as an error, and a last byte is a byte.
    a_byte_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (byte_valid || string_last) |-> byte_valid && !code_error)
        else $error("inconsistent byte result");

    // The end of stream stays until reset.
    a_end_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        stream_end |=> stream_end)
        else $error("stream end fell");

    // The reported code width stays within its legal range.
    a_width_range: assert property (@(posedge clk) disable iff (!rst_n)
        code_width >= lzwdd_pkg::MIN_WIDTH && code_width <= lzwdd_pkg::MAX_WIDTH)
        else $error("code width out of range");

endmodule

bind lzw_delta_byte_decoder_core lzwdd_checker u_lzwdd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .byte_valid (byte_valid),
    .string_last(string_last),
    .stream_end (stream_end),
    .code_width (code_width),
    .code_error (code_error)
);

// ===== tb/lzw_delta_byte_decoder_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LZW delta byte decoder core testbench
// Builds LZW code streams together with their drain ticks, predicts every
// result with a behavioral decoder of its own, drives the input channel with
// random gaps and stalls the output channel at random, and compares each
// result field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module lzw_delta_byte_decoder_core_test;

    localparam int DICT = lzwdd_pkg::DICT_CODES_DEF;
    localparam int CODE_W = lzwdd_pkg::CODE_W;
    localparam int WIDTH_W = lzwdd_pkg::WIDTH_W;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int LONG_HOLD = 300;

    typedef struct {
        logic              cmd;
        logic [CODE_W-1:0] code;
    } code_item_t;

    typedef struct {
        logic                 byte_valid;
        logic [7:0]           data_byte;
        logic                 string_last;
        logic                 stream_end;
        logic [WIDTH_W-1:0]   code_width;
        logic                 code_error;
    } decoded_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic cmd;
    logic [CODE_W-1:0] code;
    logic out_valid;
    logic out_ready;
    logic byte_valid;
    logic [7:0] data_byte;
    logic string_last;
    logic stream_end;
    logic [WIDTH_W-1:0] code_width;
    logic code_error;

    lzw_delta_byte_decoder_core u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .code        (code),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .byte_valid  (byte_valid),
        .data_byte   (data_byte),
        .string_last (string_last),
        .stream_end  (stream_end),
        .code_width  (code_width),
        .code_error  (code_error)
    );

    // Clock: 4 ns period.
    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    code_item_t pending_items[$];
    decoded_t   expected_bytes[$];
    int         mismatches;
    int         results_seen;
    int         idle_cycles;

    // Shadow decoder state. The dictionary is only read where it was written
    // in the current epoch, so it needs no clearing.
    logic [CODE_W-1:0] dict_prefix [0:DICT-1];
    logic [7:0]        dict_char   [0:DICT-1];
    logic [7:0]        rev_stack   [0:DICT-1];
    int  next_slot;
    int  cur_width;
    int  last_code;
    int  last_first;
    logic [7:0] acc_sum;
    bit  want_literal;
    int  stack_depth;
    bit  done_flag;

    // Pushes the string of a valid code onto the stack, first byte on top,
    // and returns that first byte.
    function automatic int push_string(input int c);
        int n;
        n = 0;
        while (c >= int'(lzwdd_pkg::CTRL_CLEAR) && c < DICT && n < DICT - 1)
        begin
            rev_stack[n] = dict_char[c];
            n++;
            c = dict_prefix[c];
        end
        c = c & 8'hff;
        rev_stack[n] = c[7:0];
        stack_depth = n + 1;
        return c;
    endfunction

    function automatic void grow_dict(input int pfx, input int ch);
        if (next_slot >= DICT)
            return;
        dict_prefix[next_slot] = pfx[CODE_W-1:0];
        dict_char[next_slot] = ch[7:0];
        next_slot++;
        // Early change: the width steps up one code before it is needed.
        if (cur_width < int'(lzwdd_pkg::MAX_WIDTH) && next_slot >= (1 << cur_width) - 1)
            cur_width++;
    endfunction

    function automatic bit accept_code(input int c);
        int first;
        if (stack_depth != 0 || done_flag)
            return 1'b0;
        if (c == int'(lzwdd_pkg::CTRL_CLEAR))
        begin
            acc_sum = 8'd0;
            next_slot = int'(lzwdd_pkg::FIRST_FREE);
            cur_width = int'(lzwdd_pkg::MIN_WIDTH);
            want_literal = 1'b1;
            return 1'b1;
        end
        if (c == int'(lzwdd_pkg::CTRL_END))
        begin
            done_flag = 1'b1;
            return 1'b1;
        end
        if (want_literal)
        begin
            if (c >= int'(lzwdd_pkg::CTRL_CLEAR))
                return 1'b0;
            first = push_string(c);
            last_code = c;
            last_first = c;
            want_literal = 1'b0;
            return 1'b1;
        end
        if (c < next_slot)
        begin
            first = push_string(c);
            grow_dict(last_code, first);
            last_code = c;
            last_first = first;
            return 1'b1;
        end
        // The code that is about to be defined (KwKwK).
        if (c == next_slot && next_slot < DICT)
        begin
            grow_dict(last_code, last_first);
            first = push_string(c);
            last_code = c;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic decoded_t decode_item(input logic item_cmd, input int c);
        decoded_t r;
        r.byte_valid = 1'b0;
        r.data_byte = 8'd0;
        r.string_last = 1'b0;
        r.code_error = 1'b0;
        if (item_cmd == lzwdd_pkg::CMD_CODE)
            r.code_error = !accept_code(c);
        else if (stack_depth != 0)
        begin
            stack_depth--;
            acc_sum = acc_sum + rev_stack[stack_depth];
            r.byte_valid = 1'b1;
            r.data_byte = acc_sum;
            r.string_last = (stack_depth == 0);
        end
        r.stream_end = done_flag;
        r.code_width = cur_width[WIDTH_W-1:0];
        return r;
    endfunction

    // Queues one item and its predicted result.
    function automatic void queue_item(input logic item_cmd, input int c);
        code_item_t it;
        it.cmd = item_cmd;
        it.code = c[CODE_W-1:0];
        pending_items.push_back(it);
        expected_bytes.push_back(decode_item(item_cmd, c));
    endfunction

    // Drain ticks carry a random code field, which the block must ignore.
    function automatic void drain_string();
        while (stack_depth != 0)
            queue_item(lzwdd_pkg::CMD_DRAIN, $urandom_range(0, 16383));
    endfunction

    // Picks a code that a well-formed stream could carry at this point.
    function automatic int legal_code();
        int r;
        if (want_literal)
            return $urandom_range(0, 255);
        r = $urandom_range(0, 99);
        if (r < 30 || (next_slot <= int'(lzwdd_pkg::FIRST_FREE) && r < 85))
            return $urandom_range(0, 255);
        if (r < 85)
            return $urandom_range(int'(lzwdd_pkg::FIRST_FREE), next_slot - 1);
        if (next_slot < DICT)
            return next_slot;
        return $urandom_range(0, 255);
    endfunction

    initial
    begin
        int r;
        int c;
        next_slot = int'(lzwdd_pkg::FIRST_FREE);
        cur_width = int'(lzwdd_pkg::MIN_WIDTH);
        last_code = 0;
        last_first = 0;
        acc_sum = 8'd0;
        want_literal = 1'b1;
        stack_depth = 0;
        done_flag = 1'b0;

        // Directed opening: empty drain, clear first, non-literal codes
        // right after a clear, both literal extremes, a KwKwK code, a code
        // while bytes are pending and a code beyond the next free entry.
        queue_item(lzwdd_pkg::CMD_DRAIN, 16383);
        queue_item(lzwdd_pkg::CMD_CODE, int'(lzwdd_pkg::CTRL_CLEAR));
        queue_item(lzwdd_pkg::CMD_CODE, 300);
        queue_item(lzwdd_pkg::CMD_CODE, int'(lzwdd_pkg::FIRST_FREE));
        queue_item(lzwdd_pkg::CMD_CODE, 0);
        drain_string();
        queue_item(lzwdd_pkg::CMD_CODE, 255);
        queue_item(lzwdd_pkg::CMD_CODE, 255);
        drain_string();
        queue_item(lzwdd_pkg::CMD_CODE, next_slot);
        queue_item(lzwdd_pkg::CMD_CODE, 7);
        drain_string();
        queue_item(lzwdd_pkg::CMD_CODE, 16383);
        queue_item(lzwdd_pkg::CMD_CODE, next_slot + 1);
        queue_item(lzwdd_pkg::CMD_CODE, next_slot);
        drain_string();
        queue_item(lzwdd_pkg::CMD_DRAIN, 0);

        // Random streams: mostly well-formed codes with their drains, plus
        // clears, raw noise codes, stray drains and codes sent too early.
        while (pending_items.size() < 1200)
        begin
            r = $urandom_range(0, 99);
            if (r < 4)
                queue_item(lzwdd_pkg::CMD_CODE, int'(lzwdd_pkg::CTRL_CLEAR));
            else if (r < 10)
            begin
                c = $urandom_range(0, 16383);
                if (c == int'(lzwdd_pkg::CTRL_END))
                    c = 0;
                queue_item(lzwdd_pkg::CMD_CODE, c);
            end
            else if (r < 14)
                queue_item(lzwdd_pkg::CMD_DRAIN, $urandom_range(0, 16383));
            else if (r < 18)
            begin
                queue_item(lzwdd_pkg::CMD_CODE, legal_code());
                if (stack_depth != 0)
                    queue_item(lzwdd_pkg::CMD_CODE, legal_code());
            end
            else
                queue_item(lzwdd_pkg::CMD_CODE, legal_code());
            drain_string();
        end

        // End code, then codes and drains that arrive after the end.
        queue_item(lzwdd_pkg::CMD_CODE, int'(lzwdd_pkg::CTRL_END));
        queue_item(lzwdd_pkg::CMD_CODE, 12);
        queue_item(lzwdd_pkg::CMD_CODE, int'(lzwdd_pkg::CTRL_CLEAR));
        queue_item(lzwdd_pkg::CMD_DRAIN, 5);
    end

    // Reset once at the start.
    initial
    begin
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Input driver: after each item it waits a drawn number of cycles. Every
    // few hundred items a stretch runs with no gaps at all.
    int send_gap;
    int items_sent;

    always @(posedge clk or negedge rst_n)
    begin
        code_item_t it;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            cmd <= lzwdd_pkg::CMD_CODE;
            code <= '0;
            send_gap <= 0;
            items_sent <= 0;
        end
        else if (!(in_valid && !in_ready))
        begin
            if (send_gap > 0)
            begin
                in_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (pending_items.size() != 0)
            begin
                it = pending_items.pop_front();
                in_valid <= 1'b1;
                cmd <= it.cmd;
                code <= it.code;
                items_sent <= items_sent + 1;
                send_gap <= ((items_sent / 200) % 4 == 3) ? 0 : $urandom_range(0, 9);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Output monitor: checks each result, then stalls for a drawn number of
    // cycles. Once, it holds off long enough for the block to back up and
    // drop in_ready while the driver keeps offering items.
    int hold_left;

    always @(posedge clk or negedge rst_n)
    begin
        decoded_t want;
        int hold;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left <= 0;
            results_seen <= 0;
        end
        else if (out_valid && out_ready)
        begin
            results_seen <= results_seen + 1;
            if (expected_bytes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: byte %0d data %02h", byte_valid, data_byte);
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (byte_valid !== want.byte_valid || data_byte !== want.data_byte
                    || string_last !== want.string_last || stream_end !== want.stream_end
                    || code_width !== want.code_width || code_error !== want.code_error)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("result %0d: expected v%0d d%02h l%0d e%0d w%0d x%0d,",
                            results_seen, want.byte_valid, want.data_byte,
                            want.string_last, want.stream_end, want.code_width,
                            want.code_error);
                        $display("    got v%0d d%02h l%0d e%0d w%0d x%0d",
                            byte_valid, data_byte, string_last, stream_end, code_width,
                            code_error);
                    end
                end
            end
            if (results_seen == 400)
                hold = LONG_HOLD;
            else if ((results_seen / 250) % 4 == 2)
                hold = 0;
            else
                hold = $urandom_range(0, 9);
            hold_left <= hold;
            out_ready <= (hold == 0);
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= (hold_left == 1);
        end
        else
            out_ready <= 1'b1;
    end

    // Watchdog: counts cycles in which neither channel moves an item.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // End of run: everything sent and every predicted result seen, then a
    // short tail to catch any result the block should not produce.
    initial
    begin
        @(posedge rst_n);
        @(posedge clk);
        while (pending_items.size() != 0 || expected_bytes.size() != 0 || in_valid)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
